/* src/qds_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qds_pkg: shared types and constants of the quadrature decoder
// Widths, action and register codes, the transition table, item structs.
// ----------------------------------------------------------------------------
package qds_pkg;

   localparam int HISTORY_DEPTH = 1024;
   localparam int PTR_W         = $clog2(HISTORY_DEPTH);
   localparam int FILL_W        = PTR_W + 1;

   localparam int ACTION_W   = 2;
   localparam int TIME_W     = 48;
   localparam int POS_W      = 32;
   localparam int ERR_W      = 31;
   localparam int LOOKBACK_W = 10;
   localparam int WINDOW_W   = 24;
   localparam int LB_CMP_W   = ((LOOKBACK_W > PTR_W) ? LOOKBACK_W : PTR_W) + 1;

   localparam int SCALE_W = 20;
   localparam int PROD_W  = POS_W + SCALE_W;
   localparam int QUO_W   = 32;
   localparam int REM_W   = WINDOW_W + 1;
   localparam int CNT_W   = $clog2(QUO_W);

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [LOOKBACK_W-1:0] LOOKBACK_RESET = 10'd50;
   localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 24'd100000;
   localparam logic [ERR_W-1:0]      ERR_MAX        = {ERR_W{1'b1}};
   localparam logic [SCALE_W-1:0]    US_PER_SEC     = 20'd1000000;
   localparam logic [POS_W-1:0]      SPEED_MAX      = 32'h7FFF_FFFF;
   localparam logic [POS_W-1:0]      SPEED_MIN      = 32'h8000_0000;

   // action codes of an input item
   localparam logic [ACTION_W-1:0] ACTION_SAMPLE = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_ZERO   = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_RESYNC = 2'd2;
   localparam logic [ACTION_W-1:0] ACTION_NOP    = 2'd3;

   // register indexes
   localparam logic REG_LOOKBACK = 1'b0;
   localparam logic REG_WINDOW   = 1'b1;

   // step codes from the transition table
   localparam logic [1:0] STEP_NONE    = 2'd0;
   localparam logic [1:0] STEP_UP      = 2'd1;
   localparam logic [1:0] STEP_DOWN    = 2'd2;
   localparam logic [1:0] STEP_ILLEGAL = 2'd3;

   typedef struct packed {
      logic [LOOKBACK_W-1:0] lookback;
      logic [WINDOW_W-1:0]   window;
   } cfg_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [1:0]          ab;
      logic [TIME_W-1:0]   time_us;
   } item_type;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [TIME_W-1:0] time_us;
   } ring_type;

   // previous {A,B} against current {A,B}
   function automatic logic [1:0] step_lookup(input logic [1:0] prev_ab,
                                              input logic [1:0] cur_ab);
      logic [1:0] step;
      case ({prev_ab, cur_ab})
         4'b00_00: step = STEP_NONE;
         4'b00_01: step = STEP_DOWN;
         4'b00_10: step = STEP_UP;
         4'b00_11: step = STEP_ILLEGAL;
         4'b01_00: step = STEP_UP;
         4'b01_01: step = STEP_NONE;
         4'b01_10: step = STEP_ILLEGAL;
         4'b01_11: step = STEP_DOWN;
         4'b10_00: step = STEP_DOWN;
         4'b10_01: step = STEP_ILLEGAL;
         4'b10_10: step = STEP_NONE;
         4'b10_11: step = STEP_UP;
         4'b11_00: step = STEP_ILLEGAL;
         4'b11_01: step = STEP_UP;
         4'b11_10: step = STEP_DOWN;
         default:  step = STEP_NONE;
      endcase
      return step;
   endfunction

endpackage
`default_nettype wire

/* src/qds_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qds channels: valid/ready interfaces of the decoder
// Request channel carries one sample or command, response one result.
// ----------------------------------------------------------------------------
interface qds_req_if import qds_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic                level_a;
   logic                level_b;
   logic [TIME_W-1:0]   time_us;

   modport source (output valid, action, level_a, level_b, time_us, input ready);
   modport sink   (input valid, action, level_a, level_b, time_us, output ready);
endinterface

interface qds_rsp_if import qds_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] position;
   logic [ERR_W-1:0]        error_count;
   logic signed [POS_W-1:0] speed;
   logic                    step_error;

   modport source (output valid, position, error_count, speed, step_error, input ready);
   modport sink   (input valid, position, error_count, speed, step_error, output ready);
endinterface
`default_nettype wire

/* src/qds_csr.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qds_csr: configuration registers
// APB-style write and read of the lookback and window registers.
// ----------------------------------------------------------------------------
module qds_csr import qds_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   logic                  reg_index;
   logic                  write_en;
   logic [LOOKBACK_W-1:0] lookback_ff;
   logic [WINDOW_W-1:0]   window_ff;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1];
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lookback_ff <= LOOKBACK_RESET;
         window_ff   <= WINDOW_RESET;
      end else if (write_en) begin
         case (reg_index)
            REG_LOOKBACK: lookback_ff <= csr_pwdata[LOOKBACK_W-1:0];
            REG_WINDOW:   window_ff   <= csr_pwdata[WINDOW_W-1:0];
            default:      lookback_ff <= lookback_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_LOOKBACK: csr_prdata = CSR_DATA_W'(lookback_ff);
         REG_WINDOW:   csr_prdata = CSR_DATA_W'(window_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.lookback = lookback_ff;
   assign cfg.window   = window_ff;

endmodule
`default_nettype wire

/* src/qds_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qds_front: request intake
// Accept items, pack them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module qds_front import qds_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   qds_req_if.sink   req_if,
   input  wire logic q_pop,
   output logic      q_valid,
   output item_type  q_item
);

   item_type   queue_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   item_type   item_in;

   assign req_if.ready = (count_ff != 2'd2);
   assign push         = req_if.valid & req_if.ready;
   assign q_valid      = (count_ff != 2'd0);
   assign q_item       = queue_ff[rd_ptr_ff];

   assign item_in.action  = req_if.action;
   assign item_in.ab      = {req_if.level_a, req_if.level_b};
   assign item_in.time_us = req_if.time_us;

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, q_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule
`default_nettype wire

/* src/qds_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qds_back: decoder state, history ring and speed unit
// Apply one item, log samples, then divide for speed one bit per cycle.
// ----------------------------------------------------------------------------
module qds_back import qds_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     q_valid,
   input  wire item_type q_item,
   output logic          q_pop,
   qds_rsp_if.source     rsp_if
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_UPDATE = 4'd1;
   localparam logic [3:0] S_REDUCE = 4'd2;
   localparam logic [3:0] S_READ   = 4'd3;
   localparam logic [3:0] S_CHECK  = 4'd4;
   localparam logic [3:0] S_MUL    = 4'd5;
   localparam logic [3:0] S_SAT    = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_FIX    = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;

   logic [3:0]            state_ff;
   item_type              item_ff;

   // decoder state
   logic [1:0]            prev_ab_ff;
   logic                  resync_ff;
   logic [POS_W-1:0]      raw_pos_ff;
   logic [POS_W-1:0]      zero_ff;
   logic [ERR_W-1:0]      err_ff;
   logic [PTR_W-1:0]      wp_ff;
   logic [FILL_W-1:0]     fill_ff;
   logic                  step_err_ff;

   // history ring
   ring_type              ring_mem [HISTORY_DEPTH];
   ring_type              rd_data_ff;
   logic                  ring_we;

   // speed path
   logic [LOOKBACK_W-1:0] lb_work_ff;
   logic [PTR_W-1:0]      slot_ff;
   logic                  slot_valid_ff;
   logic                  neg_ff;
   logic [POS_W-1:0]      diff_mag_ff;
   logic [WINDOW_W-1:0]   delta_ff;
   logic                  avail_ff;
   logic [PROD_W-1:0]     num_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [QUO_W-1:0]      dvd_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [POS_W-1:0]      speed_ff;

   logic                  rsp_valid_ff;

   // combinational helpers
   logic [1:0]            eff_prev;
   logic [1:0]            step;
   logic [POS_W-1:0]      raw_pos_in;
   logic [PTR_W-1:0]      wp_in;
   logic [PTR_W:0]        slot_sum;
   logic [PTR_W-1:0]      slot_in;
   logic                  lb_over;
   logic [POS_W-1:0]      diff;
   logic [TIME_W-1:0]     elapsed;
   logic                  avail_in;
   logic                  sat_in;
   logic [REM_W-1:0]      shifted;
   logic                  quo_bit;
   logic [POS_W-1:0]      speed_in;
   logic                  out_free;

   // ---- step decode ----
   always_comb begin
      eff_prev = resync_ff ? item_ff.ab : prev_ab_ff;
      step     = step_lookup(eff_prev, item_ff.ab);
      case (step)
         STEP_UP:   raw_pos_in = raw_pos_ff + POS_W'(1);
         STEP_DOWN: raw_pos_in = raw_pos_ff - POS_W'(1);
         default:   raw_pos_in = raw_pos_ff;
      endcase
   end

   assign wp_in   = (PTR_W'(HISTORY_DEPTH - 1) == wp_ff) ? '0 : wp_ff + PTR_W'(1);
   assign ring_we = (state_ff == S_UPDATE) && (item_ff.action == ACTION_SAMPLE);

   // ---- slot selection ----
   assign lb_over  = LB_CMP_W'(lb_work_ff) >= LB_CMP_W'(HISTORY_DEPTH);
   assign slot_sum = (PTR_W+1)'(wp_ff) + (PTR_W+1)'(lb_work_ff);
   assign slot_in  = (slot_sum >= (PTR_W+1)'(HISTORY_DEPTH))
                   ? PTR_W'(slot_sum - (PTR_W+1)'(HISTORY_DEPTH))
                   : PTR_W'(slot_sum);

   // ---- availability and magnitude ----
   assign diff     = raw_pos_ff - rd_data_ff.pos;
   assign elapsed  = item_ff.time_us - rd_data_ff.time_us;
   assign avail_in = slot_valid_ff && (item_ff.time_us > rd_data_ff.time_us)
                     && (elapsed <= TIME_W'(cfg.window));

   // quotient reaches 2^32 or more: clamp without dividing
   assign sat_in = (WINDOW_W+QUO_W)'(num_ff) >= {delta_ff, {QUO_W{1'b0}}};

   // ---- restoring divide step ----
   assign shifted = {rem_ff[REM_W-2:0], dvd_ff[QUO_W-1]};
   assign quo_bit = shifted >= REM_W'(delta_ff);

   // ---- sign and clamp ----
   always_comb begin
      if (neg_ff) begin
         speed_in = (dvd_ff > SPEED_MIN) ? SPEED_MIN : (~dvd_ff + POS_W'(1));
      end else begin
         speed_in = dvd_ff[QUO_W-1] ? SPEED_MAX : dvd_ff;
      end
   end

   assign out_free = ~rsp_valid_ff | rsp_if.ready;
   assign q_pop    = (state_ff == S_IDLE) & q_valid;

   // ---- ring memory ----
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wp_ff] <= '{pos: raw_pos_in, time_us: item_ff.time_us};
      end
      if (state_ff == S_READ) begin
         rd_data_ff <= ring_mem[slot_ff];
      end
   end

   // ---- sequencer and decoder state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_ab_ff   <= 2'b00;
         resync_ff    <= 1'b1;
         raw_pos_ff   <= '0;
         zero_ff      <= '0;
         err_ff       <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop a taken result unless the next one loads in this cycle
         if (rsp_valid_ff && rsp_if.ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               case (item_ff.action)
                  ACTION_SAMPLE: begin
                     prev_ab_ff <= item_ff.ab;
                     resync_ff  <= 1'b0;
                     raw_pos_ff <= raw_pos_in;
                     if ((step == STEP_ILLEGAL) && (err_ff != ERR_MAX)) begin
                        err_ff <= err_ff + ERR_W'(1);
                     end
                     wp_ff <= wp_in;
                     if (fill_ff != FILL_W'(HISTORY_DEPTH)) begin
                        fill_ff <= fill_ff + FILL_W'(1);
                     end
                  end
                  ACTION_ZERO:   zero_ff   <= raw_pos_ff;
                  ACTION_RESYNC: resync_ff <= 1'b1;
                  default:       zero_ff   <= zero_ff;
               endcase
               state_ff <= S_REDUCE;
            end
            S_REDUCE: begin
               if (!lb_over) begin
                  state_ff <= S_READ;
               end
            end
            S_READ:  state_ff <= S_CHECK;
            S_CHECK: state_ff <= S_MUL;
            S_MUL:   state_ff <= S_SAT;
            S_SAT: begin
               if (!avail_ff || sat_in) begin
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (cnt_ff == CNT_W'(QUO_W - 1)) begin
                  state_ff <= S_FIX;
               end
            end
            S_FIX: state_ff <= S_OUT;
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // ---- datapath registers ----
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            item_ff <= q_item;
         end
         S_UPDATE: begin
            step_err_ff <= (item_ff.action == ACTION_SAMPLE) && (step == STEP_ILLEGAL);
            lb_work_ff  <= cfg.lookback;
         end
         S_REDUCE: begin
            if (lb_over) begin
               lb_work_ff <= lb_work_ff - LOOKBACK_W'(HISTORY_DEPTH);
            end else begin
               slot_ff <= slot_in;
            end
         end
         S_READ: begin
            slot_valid_ff <= FILL_W'(slot_ff) < fill_ff;
         end
         S_CHECK: begin
            neg_ff      <= diff[POS_W-1];
            diff_mag_ff <= diff[POS_W-1] ? (~diff + POS_W'(1)) : diff;
            delta_ff    <= elapsed[WINDOW_W-1:0];
            avail_ff    <= avail_in;
         end
         S_MUL: begin
            num_ff <= PROD_W'(diff_mag_ff) * PROD_W'(US_PER_SEC);
         end
         S_SAT: begin
            rem_ff <= REM_W'(num_ff[PROD_W-1:QUO_W]);
            dvd_ff <= num_ff[QUO_W-1:0];
            cnt_ff <= '0;
            if (!avail_ff) begin
               speed_ff <= '0;
            end else if (sat_in) begin
               speed_ff <= neg_ff ? SPEED_MIN : SPEED_MAX;
            end
         end
         S_DIV: begin
            rem_ff <= quo_bit ? (shifted - REM_W'(delta_ff)) : shifted;
            dvd_ff <= {dvd_ff[QUO_W-2:0], quo_bit};
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         S_FIX: begin
            speed_ff <= speed_in;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_if.position    <= raw_pos_ff - zero_ff;
               rsp_if.error_count <= err_ff;
               rsp_if.speed       <= speed_ff;
               rsp_if.step_error  <= step_err_ff;
            end
         end
         default: cnt_ff <= cnt_ff;
      endcase
   end

   assign rsp_if.valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* src/quadrature_decoder_with_speed_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_decoder_with_speed_core: x4 quadrature decoder with speed
// Position, error count and counts-per-second speed from polled A/B levels.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one item per handshake: an action (sample, zero the
//   reported position, resync, or no operation), the A/B levels and a
//   microsecond timestamp. rsp_if returns exactly one result per item, in
//   order: position, error count, speed and a step error flag.
//   The csr_* port sets the history lookback (offset 0) and the speed
//   window in microseconds (offset 4); write it only while the block idles.
// Processing:
//   An item passes through update, lookback reduction, ring read, check,
//   multiply and saturation states, then the restoring divider of the speed
//   unit, the sign fix and the output register. Speed that is unavailable
//   or that saturates skips the divider and the sign fix. Items are worked
//   one at a time; a two-entry queue keeps accepting while one is in work.
// Reset:
//   Clear position, offset, error count, write pointer and fill count, arm
//   resync, load register defaults. No clearing pass runs on the ring.
// Stall:
//   A result waits in the output register; the back end holds the next
//   result until that register frees, and the queue stops accepting once full.
// ----------------------------------------------------------------------------
module quadrature_decoder_with_speed_core import qds_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   qds_req_if.sink                    req_if,
   qds_rsp_if.source                  rsp_if,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type  cfg;
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   // register file
   qds_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // accept and queue items
   qds_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_item  (q_item)
   );

   // decode, log and compute speed
   qds_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule
`default_nettype wire
